>>> hw/rtl/pitri_pkg.sv
// shared constants for the point-in-triangle area test
// depends on nothing; used by the interfaces and all rtl modules but pitri_isqrt and pitri_checker
package pitri_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 4;
   localparam int MARGIN_WIDTH    = 32;
   localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = 32'd16;

   // point slots
   localparam int PT_A    = 0;
   localparam int PT_B    = 1;
   localparam int PT_C    = 2;
   localparam int PT_P    = 3;
   localparam int NUM_PTS = 4;

   // distance lanes
   localparam int D_AC     = 0;
   localparam int D_AB     = 1;
   localparam int D_BC     = 2;
   localparam int D_AP     = 3;
   localparam int D_BP     = 4;
   localparam int D_CP     = 5;
   localparam int NUM_DIST = 6;

   localparam int DIST_FROM [NUM_DIST] = '{PT_A, PT_A, PT_B, PT_A, PT_B, PT_C};
   localparam int DIST_TO   [NUM_DIST] = '{PT_C, PT_B, PT_C, PT_P, PT_P, PT_P};

   // triangle lanes: whole triangle first, then the three sub-triangles
   localparam int T_ABC   = 0;
   localparam int NUM_TRI = 4;
   localparam int TRI_SIDE [NUM_TRI][3] = '{
      '{D_AC, D_AB, D_BC},
      '{D_AC, D_CP, D_AP},
      '{D_AB, D_AP, D_BP},
      '{D_BC, D_CP, D_BP}
   };

endpackage

>>> hw/rtl/pitri_if.sv
// request and response channel interfaces of the point-in-triangle test
// depends on pitri_pkg
interface pitri_req_if #(
   parameter int COORD_WIDTH = pitri_pkg::COORD_WIDTH_DEF
);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] vert_a_x;
   logic signed [COORD_WIDTH-1:0] vert_a_y;
   logic signed [COORD_WIDTH-1:0] vert_b_x;
   logic signed [COORD_WIDTH-1:0] vert_b_y;
   logic signed [COORD_WIDTH-1:0] vert_c_x;
   logic signed [COORD_WIDTH-1:0] vert_c_y;
   logic signed [COORD_WIDTH-1:0] probe_x;
   logic signed [COORD_WIDTH-1:0] probe_y;

   modport source (output valid, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
                   vert_c_x, vert_c_y, probe_x, probe_y, input ready);
   modport sink   (input valid, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
                   vert_c_x, vert_c_y, probe_x, probe_y, output ready);
endinterface

interface pitri_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

>>> hw/rtl/pitri_isqrt.sv
// pipelined floored square root, one result bit per stage, several lanes
// depends on nothing outside this file
module pitri_isqrt #(
   parameter int IN_W  = 33,
   parameter int LANES = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [LANES-1:0][IN_W-1:0]          rad_in,
   output logic                                out_valid,
   output logic [LANES-1:0][(IN_W+1)/2-1:0]    root_out
);
   localparam int K  = (IN_W + 1) / 2;
   localparam int RW = 2 * K + 1;

   logic [RW-1:0] rem_ff [K][LANES];
   logic [RW-1:0] res_ff [K][LANES];
   logic [RW-1:0] rem_in [K][LANES];
   logic [RW-1:0] res_in [K][LANES];
   logic [K-1:0]  vld_ff;
   logic [K-1:0]  vld_in;

   always_comb begin
      int prv;
      logic [RW-1:0] cur_rem;
      logic [RW-1:0] cur_res;
      logic [RW-1:0] trial;
      logic [RW-1:0] step_bit;
      for (int s = 0; s < K; s++) begin
         prv       = (s == 0) ? 0 : s - 1;
         vld_in[s] = (s == 0) ? in_valid : vld_ff[prv];
         step_bit  = RW'(1) << (2 * (K - 1 - s));
         for (int l = 0; l < LANES; l++) begin
            cur_rem = (s == 0) ? RW'(rad_in[l]) : rem_ff[prv][l];
            cur_res = (s == 0) ? '0 : res_ff[prv][l];
            trial   = cur_res + step_bit;
            if (cur_rem >= trial) begin
               rem_in[s][l] = cur_rem - trial;
               res_in[s][l] = (cur_res >> 1) + step_bit;
            end else begin
               rem_in[s][l] = cur_rem;
               res_in[s][l] = cur_res >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
      if (en) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         root_out[l] = res_ff[K-1][l][K-1:0];
      end
   end
   assign out_valid = vld_ff[K-1];

endmodule

>>> hw/rtl/pitri_dist.sv
// squared distances of the six point pairs: difference, square, sum stages
// depends on pitri_pkg
module pitri_dist #(
   parameter int COORD_WIDTH = pitri_pkg::COORD_WIDTH_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               en,
   input  logic                                               in_valid,
   input  logic signed [COORD_WIDTH-1:0]                      pt_x [pitri_pkg::NUM_PTS],
   input  logic signed [COORD_WIDTH-1:0]                      pt_y [pitri_pkg::NUM_PTS],
   output logic                                               out_valid,
   output logic [pitri_pkg::NUM_DIST-1:0][2*COORD_WIDTH:0]    sq_out
);
   localparam int W  = COORD_WIDTH;
   localparam int ND = pitri_pkg::NUM_DIST;

   logic [W-1:0]   dx_ff [ND], dy_ff [ND], dx_in [ND], dy_in [ND];
   logic [2*W-1:0] sqx_ff [ND], sqy_ff [ND];
   logic [2*W:0]   sum_ff [ND];
   logic [2:0]     vld_ff;

   // magnitude of each coordinate difference
   always_comb begin
      logic [W:0] ddx;
      logic [W:0] ddy;
      for (int l = 0; l < ND; l++) begin
         ddx = {pt_x[pitri_pkg::DIST_TO[l]][W-1], pt_x[pitri_pkg::DIST_TO[l]]}
             - {pt_x[pitri_pkg::DIST_FROM[l]][W-1], pt_x[pitri_pkg::DIST_FROM[l]]};
         ddy = {pt_y[pitri_pkg::DIST_TO[l]][W-1], pt_y[pitri_pkg::DIST_TO[l]]}
             - {pt_y[pitri_pkg::DIST_FROM[l]][W-1], pt_y[pitri_pkg::DIST_FROM[l]]};
         if (ddx[W]) ddx = -ddx;
         if (ddy[W]) ddy = -ddy;
         dx_in[l] = ddx[W-1:0];
         dy_in[l] = ddy[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
      if (en) begin
         for (int l = 0; l < ND; l++) begin
            dx_ff[l]  <= dx_in[l];
            dy_ff[l]  <= dy_in[l];
            sqx_ff[l] <= (2*W)'(dx_ff[l]) * (2*W)'(dx_ff[l]);
            sqy_ff[l] <= (2*W)'(dy_ff[l]) * (2*W)'(dy_ff[l]);
            sum_ff[l] <= (2*W+1)'(sqx_ff[l]) + (2*W+1)'(sqy_ff[l]);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < ND; l++) begin
         sq_out[l] = sum_ff[l];
      end
   end
   assign out_valid = vld_ff[2];

endmodule

>>> hw/rtl/pitri_heron.sv
// heron product magnitude of four triangles from their side lengths
// depends on pitri_pkg
module pitri_heron #(
   parameter int DW = pitri_pkg::COORD_WIDTH_DEF + 1
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       en,
   input  logic                                       in_valid,
   input  logic [pitri_pkg::NUM_DIST-1:0][DW-1:0]     dist_in,
   output logic                                       out_valid,
   output logic [pitri_pkg::NUM_TRI-1:0][4*DW+7:0]    q_out
);
   localparam int TW = DW + 2;
   localparam int TS = DW + 3;
   localparam int QW = 4 * TW;
   localparam int NT = pitri_pkg::NUM_TRI;

   logic [TW-1:0]   term_ff [NT][4];
   logic [TW-1:0]   term_in [NT][4];
   logic [2*TW-1:0] m1_ff [NT], m2_ff [NT];
   logic [3*TW-1:0] pl_ff [NT], ph_ff [NT];
   logic [QW-1:0]   q_ff [NT];
   logic [3:0]      vld_ff;

   // four heron factors, taken as magnitudes
   always_comb begin
      logic [TS-1:0] sa, sb, sc;
      logic [TS-1:0] f [4];
      for (int t = 0; t < NT; t++) begin
         sa   = TS'(dist_in[pitri_pkg::TRI_SIDE[t][0]]);
         sb   = TS'(dist_in[pitri_pkg::TRI_SIDE[t][1]]);
         sc   = TS'(dist_in[pitri_pkg::TRI_SIDE[t][2]]);
         f[0] = sa + sb + sc;
         f[1] = sb + sc - sa;
         f[2] = sa + sc - sb;
         f[3] = sa + sb - sc;
         for (int k = 0; k < 4; k++) begin
            if (f[k][TS-1]) f[k] = -f[k];
            term_in[t][k] = f[k][TW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
      if (en) begin
         term_ff <= term_in;
         for (int t = 0; t < NT; t++) begin
            m1_ff[t] <= (2*TW)'(term_ff[t][0]) * (2*TW)'(term_ff[t][1]);
            m2_ff[t] <= (2*TW)'(term_ff[t][2]) * (2*TW)'(term_ff[t][3]);
            pl_ff[t] <= (3*TW)'(m1_ff[t]) * (3*TW)'(m2_ff[t][TW-1:0]);
            ph_ff[t] <= (3*TW)'(m1_ff[t]) * (3*TW)'(m2_ff[t][2*TW-1:TW]);
            q_ff[t]  <= QW'(pl_ff[t]) + (QW'(ph_ff[t]) << TW);
         end
      end
   end

   always_comb begin
      for (int t = 0; t < NT; t++) begin
         q_out[t] = q_ff[t];
      end
   end
   assign out_valid = vld_ff[3];

endmodule

>>> hw/rtl/pitri_cmp.sv
// sums the sub-areas, takes the difference to the whole and tests the margin
// depends on pitri_pkg
module pitri_cmp #(
   parameter int AW        = 2 * (pitri_pkg::COORD_WIDTH_DEF + 3),
   parameter int FRAC_BITS = pitri_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic [pitri_pkg::NUM_TRI-1:0][AW-1:0]    area_in,
   input  logic [pitri_pkg::MARGIN_WIDTH-1:0]       margin,
   output logic                                     out_valid,
   output logic                                     in_tri
);
   localparam int PW = AW + 2;
   localparam int MW = pitri_pkg::MARGIN_WIDTH + FRAC_BITS + 2;
   localparam int CW = (PW > MW) ? PW : MW;

   logic [AW-1:0] whole1_ff, whole2_ff, last1_ff;
   logic [PW-1:0] pair_ff, parts_ff;
   logic [CW-1:0] diff_ff, lim;
   logic          inside_ff;
   logic [3:0]    vld_ff;

   // margin moved to the area scale
   assign lim = CW'(margin) << (FRAC_BITS + 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
      if (en) begin
         whole1_ff <= area_in[pitri_pkg::T_ABC];
         pair_ff   <= PW'(area_in[1]) + PW'(area_in[2]);
         last1_ff  <= area_in[3];
         whole2_ff <= whole1_ff;
         parts_ff  <= pair_ff + PW'(last1_ff);
         if (PW'(whole2_ff) >= parts_ff) begin
            diff_ff <= CW'(PW'(whole2_ff) - parts_ff);
         end else begin
            diff_ff <= CW'(parts_ff - PW'(whole2_ff));
         end
         inside_ff <= (diff_ff <= lim);
      end
   end

   assign out_valid = vld_ff[3];
   assign in_tri    = inside_ff;

endmodule

>>> hw/rtl/point_in_triangle_area_test.sv
// top level of the heron-area point-in-triangle test
// depends on pitri_pkg, pitri_if, pitri_dist, pitri_isqrt, pitri_heron, pitri_cmp
//
// usage
//   req_chan carries one word: triangle vertices a, b, c and a probe point,
//   all signed fixed point with FRAC_BITS fraction bits. rsp_chan returns one
//   word per request: inside_res is 1 when |area(abc) - sum of the three
//   sub-areas| <= area_margin (boundary counts as inside).
//   csr_we/csr_wdata write area_margin; write it only while no word is in
//   flight. reset value of the margin is 16.
// pipeline and throughput
//   from request accept to response valid a word passes 3 distance stages,
//   COORD_WIDTH+1 root stages, 4 heron stages, 2*COORD_WIDTH+6 root stages,
//   4 compare stages and the output register. one word can enter every
//   cycle while req_chan.ready is high; the two root pipelines set the depth.
// reset and stalls
//   synchronous reset empties the pipeline and the output register. when
//   the receiver stalls, the output register holds and one more word lands
//   in the skid register; only then does req_chan.ready drop and the whole
//   pipeline freeze, so nothing is lost or repeated.
module point_in_triangle_area_test #(
   parameter int COORD_WIDTH = pitri_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = pitri_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pitri_req_if.sink                            req_chan,
   pitri_rsp_if.source                          rsp_chan,
   input  logic                                 csr_we,
   input  logic [pitri_pkg::MARGIN_WIDTH-1:0]   csr_wdata
);
   // internal widths, all following from the coordinate width
   localparam int SQ_W = 2 * COORD_WIDTH + 1;   // squared distance
   localparam int DW   = (SQ_W + 1) / 2;        // distance
   localparam int QW   = 4 * (DW + 2);          // heron product
   localparam int AW   = (QW + 1) / 2;          // 4*area

   logic                                     pipe_en;
   logic signed [COORD_WIDTH-1:0]            pt_x [pitri_pkg::NUM_PTS];
   logic signed [COORD_WIDTH-1:0]            pt_y [pitri_pkg::NUM_PTS];
   logic                                     sq_v, dist_v, q_v, area_v, cmp_v;
   logic [pitri_pkg::NUM_DIST-1:0][SQ_W-1:0] sq;
   logic [pitri_pkg::NUM_DIST-1:0][DW-1:0]   dist_len;
   logic [pitri_pkg::NUM_TRI-1:0][QW-1:0]    q;
   logic [pitri_pkg::NUM_TRI-1:0][AW-1:0]    area;
   logic                                     cmp_inside;

   logic [pitri_pkg::MARGIN_WIDTH-1:0]       margin_ff;
   logic                                     out_v_ff, out_d_ff;
   logic                                     skid_v_ff, skid_d_ff;

   // margin register
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= pitri_pkg::MARGIN_RESET;
      end else if (csr_we) begin
         margin_ff <= csr_wdata;
      end
   end

   // the pipeline moves whenever the skid slot is free
   assign pipe_en        = !skid_v_ff;
   assign req_chan.ready = pipe_en;

   // request word into point slots
   assign pt_x[pitri_pkg::PT_A] = req_chan.vert_a_x;
   assign pt_y[pitri_pkg::PT_A] = req_chan.vert_a_y;
   assign pt_x[pitri_pkg::PT_B] = req_chan.vert_b_x;
   assign pt_y[pitri_pkg::PT_B] = req_chan.vert_b_y;
   assign pt_x[pitri_pkg::PT_C] = req_chan.vert_c_x;
   assign pt_y[pitri_pkg::PT_C] = req_chan.vert_c_y;
   assign pt_x[pitri_pkg::PT_P] = req_chan.probe_x;
   assign pt_y[pitri_pkg::PT_P] = req_chan.probe_y;

   // squared distances of the six pairs
   pitri_dist #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_chan.valid),
      .pt_x      (pt_x),
      .pt_y      (pt_y),
      .out_valid (sq_v),
      .sq_out    (sq)
   );

   // distances
   pitri_isqrt #(
      .IN_W  (SQ_W),
      .LANES (pitri_pkg::NUM_DIST)
   ) u_dist_root (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (sq_v),
      .rad_in    (sq),
      .out_valid (dist_v),
      .root_out  (dist_len)
   );

   // heron products, 16*area^2 magnitude
   pitri_heron #(
      .DW (DW)
   ) u_heron (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (dist_v),
      .dist_in   (dist_len),
      .out_valid (q_v),
      .q_out     (q)
   );

   // 4*area for each triangle
   pitri_isqrt #(
      .IN_W  (QW),
      .LANES (pitri_pkg::NUM_TRI)
   ) u_area_root (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (q_v),
      .rad_in    (q),
      .out_valid (area_v),
      .root_out  (area)
   );

   // area sum, difference and margin test
   pitri_cmp #(
      .AW        (AW),
      .FRAC_BITS (FRAC_BITS)
   ) u_cmp (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (area_v),
      .area_in   (area),
      .margin    (margin_ff),
      .out_valid (cmp_v),
      .in_tri    (cmp_inside)
   );

   // output register with one skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         // pipeline frozen, drain the skid slot once the word is taken
         if (rsp_chan.ready) begin
            out_v_ff  <= 1'b1;
            out_d_ff  <= skid_d_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (out_v_ff && !rsp_chan.ready) begin
         // output stalled, park the word leaving the pipeline
         if (cmp_v) begin
            skid_v_ff <= 1'b1;
            skid_d_ff <= cmp_inside;
         end
      end else begin
         out_v_ff <= cmp_v;
         out_d_ff <= cmp_inside;
      end
   end

   assign rsp_chan.valid      = out_v_ff;
   assign rsp_chan.inside_res = out_d_ff;

endmodule

>>> hw/rtl/pitri_checker.sv
// port-level checks of the point-in-triangle test, bound to the top level
// depends on point_in_triangle_area_test
module pitri_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic inside_res
);
   logic [7:0] pend_ff;

   // words accepted but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 8'(req_valid && req_ready) - 8'(rsp_valid && rsp_ready);
      end
   end

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not empty after reset");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 8'd0))
      else $error("response without pending request");

   a_ready_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request side stalled with no waiting response");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(inside_res)))
      else $error("stalled response changed");

endmodule

bind point_in_triangle_area_test pitri_checker u_pitri_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .inside_res (rsp_chan.inside_res)
);
